/* rtl/mssa_pkg.sv */
package mssa_pkg;

    localparam int POOL_SLOTS  = 1024;
    localparam int MAG_DEPTH   = 31;
    localparam int SHELL_COUNT = 8;

    localparam int SLOT_W  = 10;
    localparam int CFG_W   = 11;
    localparam int FILL_W  = 5;
    localparam int SHELL_W = 3;
    localparam int QCNT_W  = 4;
    localparam int MADDR_W = 8;
    localparam int MAG_ENTRIES = SHELL_COUNT * MAG_DEPTH;
    localparam int STK_W   = 11;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SLOTS = 2'd1;
    localparam logic [1:0] ST_NO_SHELL = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                 present;
        logic [SHELL_W-1:0]   shell;
    } mag_ref_t;

    // Request from the sequencer to the pool.
    typedef struct packed {
        logic                 take;
        logic                 give;
        logic [SLOT_W-1:0]    give_slot;
    } pool_req_t;

    // Pool answer; the recycled-stack read data is registered and appears in the cycle after take.
    typedef struct packed {
        logic                 can_take;
        logic                 from_stack;
        logic [SLOT_W-1:0]    bump_slot;
        logic [SLOT_W-1:0]    stack_slot;
        logic [CFG_W-1:0]     in_use;
    } pool_rsp_t;

    function automatic logic [MADDR_W-1:0] mag_addr(input logic [SHELL_W-1:0] shell,
                                                   input logic [FILL_W-1:0] pos);
        logic [MADDR_W+1:0] a;
        a = (MADDR_W+2)'(shell) * (MADDR_W+2)'(MAG_DEPTH) + (MADDR_W+2)'(pos);
        return a[MADDR_W-1:0];
    endfunction

endpackage

/* rtl/mssa_pool.sv */
module mssa_pool (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [mssa_pkg::CFG_W-1:0]    cfg_data,
    input  mssa_pkg::pool_req_t           req,
    output mssa_pkg::pool_rsp_t           rsp
);
    import mssa_pkg::*;

    logic [SLOT_W-1:0] stack_mem [POOL_SLOTS];
    logic [CFG_W-1:0]  slot_count_reg;
    logic [STK_W-1:0]  top_reg, top_next;
    logic [CFG_W-1:0]  bump_reg, bump_next;
    logic [SLOT_W-1:0] rd_reg;
    logic [CFG_W-1:0]  in_use;

    assign in_use = (slot_count_reg < CFG_W'(POOL_SLOTS)) ? slot_count_reg
                                                          : CFG_W'(POOL_SLOTS);

    always_comb
    begin
        top_next  = top_reg;
        bump_next = bump_reg;
        if (req.take)
        begin
            if (top_reg != '0)
            begin
                top_next = top_reg - STK_W'(1);
            end
            else if (bump_reg < in_use)
            begin
                bump_next = bump_reg + CFG_W'(1);
            end
        end
        else if (req.give && top_reg < STK_W'(POOL_SLOTS))
        begin
            top_next = top_reg + STK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= CFG_W'(1024);
            top_reg        <= '0;
            bump_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                slot_count_reg <= cfg_data;
            end
            top_reg  <= top_next;
            bump_reg <= bump_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.take)
        begin
            rd_reg <= stack_mem[top_reg[SLOT_W-1:0] - SLOT_W'(1)];
        end
        if (req.give && !req.take && top_reg < STK_W'(POOL_SLOTS))
        begin
            stack_mem[top_reg[SLOT_W-1:0]] <= req.give_slot;
        end
    end

    assign rsp.can_take   = (top_reg != '0) || (bump_reg < in_use);
    assign rsp.from_stack = (top_reg != '0);
    assign rsp.bump_slot  = bump_reg[SLOT_W-1:0];
    assign rsp.stack_slot = rd_reg;
    assign rsp.in_use     = in_use;

endmodule

/* rtl/magazine_slab_slot_allocator.sv */
// Allocator of object slot numbers from one pool, behind two magazines and a depot of
// full magazines. Each operation is a word on the input channel and gives exactly one
// word on the output channel. An allocation that a magazine serves goes through decode,
// the registered read of the magazine store, presenting the result and back to idle.
// A free, or an allocation that finds no shell, goes from decode straight to presenting
// the result. A refill from the pool alternates a take from the pool, recycled stack
// first and bump pointer next, with a write into the magazine store, until the magazine
// holds all 31 slots or the pool is empty. The block takes no new word until its result
// has been accepted, so output stalls hold it up.
module magazine_slab_slot_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mssa_pkg::CFG_W-1:0]    slot_count,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [mssa_pkg::SLOT_W-1:0]   slot_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [mssa_pkg::SLOT_W-1:0]   granted_slot
);
    import mssa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_FTAKE = 7'b0000100,
        S_FPUT  = 7'b0001000,
        S_FEND  = 7'b0010000,
        S_RD    = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] mag_mem [MAG_ENTRIES];
    logic [FILL_W-1:0] fill_reg [SHELL_COUNT];
    logic [FILL_W-1:0] fill_next [SHELL_COUNT];
    mag_ref_t ld_reg, ld_next, pv_reg, pv_next;
    logic [SHELL_W-1:0] fq_reg [SHELL_COUNT];
    logic [SHELL_W-1:0] fq_next [SHELL_COUNT];
    logic [SHELL_W-1:0] eq_reg [SHELL_COUNT];
    logic [SHELL_W-1:0] eq_next [SHELL_COUNT];
    logic [SHELL_W-1:0] fh_reg, fh_next, eh_reg, eh_next;
    logic [QCNT_W-1:0]  fc_reg, fc_next, ec_reg, ec_next;
    logic               op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SHELL_W-1:0] sh_reg, sh_next;
    logic               take_src_reg;
    logic [SLOT_W-1:0]  bump_cap_reg;
    logic [1:0]         st_reg, st_next;
    logic [SLOT_W-1:0]  gr_reg;
    logic               rd_wait_reg, rd_wait_next;

    logic               mwe;
    logic [MADDR_W-1:0] maddr_w, maddr_r;
    logic [SLOT_W-1:0]  mwdata;
    logic               mre;
    logic [SLOT_W-1:0]  mrd_reg;

    pool_req_t preq;
    pool_rsp_t prsp;

    mssa_pool u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (slot_count),
        .req       (preq),
        .rsp       (prsp)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;
    assign granted_slot = gr_reg;

    always_comb
    begin
        logic [FILL_W-1:0] lf, pf, sf;
        logic ld_has, pv_has, ld_room, pv_room;
        state_next = state_reg;
        fill_next = fill_reg;
        ld_next = ld_reg;
        pv_next = pv_reg;
        fq_next = fq_reg;
        eq_next = eq_reg;
        fh_next = fh_reg;
        eh_next = eh_reg;
        fc_next = fc_reg;
        ec_next = ec_reg;
        sh_next = sh_reg;
        st_next = st_reg;
        rd_wait_next = 1'b0;
        mwe = 1'b0;
        maddr_w = '0;
        mwdata = slot_reg;
        mre = 1'b0;
        maddr_r = '0;
        preq = '0;
        preq.give_slot = slot_reg;
        lf = fill_reg[ld_reg.shell];
        pf = fill_reg[pv_reg.shell];
        sf = fill_reg[sh_reg];
        ld_has  = ld_reg.present && lf != '0;
        pv_has  = pv_reg.present && pf != '0;
        ld_room = ld_reg.present && lf < FILL_W'(MAG_DEPTH);
        pv_room = pv_reg.present && pf < FILL_W'(MAG_DEPTH);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next = ST_DONE;
                state_next = S_OUT;
                if (op_reg == OP_ALLOC)
                begin
                    priority if (ld_has)
                    begin
                        sh_next = ld_reg.shell;
                        state_next = S_RD;
                    end
                    else if (pv_has)
                    begin
                        ld_next = pv_reg;
                        pv_next = ld_reg;
                        sh_next = pv_reg.shell;
                        state_next = S_RD;
                    end
                    else if (fc_reg != '0)
                    begin
                        sh_next = fq_reg[fh_reg];
                        fh_next = fh_reg + SHELL_W'(1);
                        fc_next = fc_reg - QCNT_W'(1);
                        if (ld_reg.present && ec_reg < QCNT_W'(SHELL_COUNT))
                        begin
                            eq_next[eh_reg + ec_reg[SHELL_W-1:0]] = ld_reg.shell;
                            ec_next = ec_reg + QCNT_W'(1);
                        end
                        ld_next.present = 1'b1;
                        ld_next.shell = fq_reg[fh_reg];
                        state_next = S_RD;
                    end
                    else if (ec_reg == '0)
                    begin
                        st_next = ST_NO_SHELL;
                    end
                    else
                    begin
                        sh_next = eq_reg[eh_reg];
                        eh_next = eh_reg + SHELL_W'(1);
                        ec_next = ec_reg - QCNT_W'(1);
                        state_next = S_FTAKE;
                    end
                end
                else if ({1'b0, slot_reg} >= prsp.in_use)
                begin
                    state_next = S_OUT;
                end
                else if (ld_room)
                begin
                    mwe = 1'b1;
                    maddr_w = mag_addr(ld_reg.shell, lf);
                    fill_next[ld_reg.shell] = lf + FILL_W'(1);
                end
                else if (pv_room)
                begin
                    ld_next = pv_reg;
                    pv_next = ld_reg;
                    mwe = 1'b1;
                    maddr_w = mag_addr(pv_reg.shell, pf);
                    fill_next[pv_reg.shell] = pf + FILL_W'(1);
                end
                else
                begin
                    if (ld_reg.present)
                    begin
                        if (fc_reg < QCNT_W'(SHELL_COUNT))
                        begin
                            fq_next[fh_reg + fc_reg[SHELL_W-1:0]] = ld_reg.shell;
                            fc_next = fc_reg + QCNT_W'(1);
                        end
                        ld_next.present = 1'b0;
                    end
                    if (ec_reg != '0)
                    begin
                        eh_next = eh_reg + SHELL_W'(1);
                        ec_next = ec_reg - QCNT_W'(1);
                        ld_next.present = 1'b1;
                        ld_next.shell = eq_reg[eh_reg];
                        mwe = 1'b1;
                        maddr_w = mag_addr(eq_reg[eh_reg], fill_reg[eq_reg[eh_reg]]);
                        fill_next[eq_reg[eh_reg]] = fill_reg[eq_reg[eh_reg]] + FILL_W'(1);
                    end
                    else
                    begin
                        preq.give = 1'b1;
                    end
                end
            end
            S_FTAKE:
            begin
                if (sf < FILL_W'(MAG_DEPTH) && prsp.can_take)
                begin
                    preq.take = 1'b1;
                    state_next = S_FPUT;
                end
                else
                begin
                    state_next = S_FEND;
                end
            end
            S_FPUT:
            begin
                mwe = 1'b1;
                maddr_w = mag_addr(sh_reg, sf);
                mwdata = take_src_reg ? prsp.stack_slot : bump_cap_reg;
                fill_next[sh_reg] = sf + FILL_W'(1);
                state_next = S_FTAKE;
            end
            S_FEND:
            begin
                if (sf == '0)
                begin
                    if (ec_reg < QCNT_W'(SHELL_COUNT))
                    begin
                        eq_next[eh_reg + ec_reg[SHELL_W-1:0]] = sh_reg;
                        ec_next = ec_reg + QCNT_W'(1);
                    end
                    st_next = ST_NO_SLOTS;
                    state_next = S_OUT;
                end
                else
                begin
                    if (ld_reg.present && ec_reg < QCNT_W'(SHELL_COUNT))
                    begin
                        eq_next[eh_reg + ec_reg[SHELL_W-1:0]] = ld_reg.shell;
                        ec_next = ec_reg + QCNT_W'(1);
                    end
                    ld_next.present = 1'b1;
                    ld_next.shell = sh_reg;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (!rd_wait_reg)
                begin
                    mre = 1'b1;
                    maddr_r = mag_addr(sh_reg, sf - FILL_W'(1));
                    fill_next[sh_reg] = sf - FILL_W'(1);
                    rd_wait_next = 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            mag_mem[maddr_w] <= mwdata;
        end
        if (mre)
        begin
            mrd_reg <= mag_mem[maddr_r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= op;
            slot_reg <= slot_index;
        end
        sh_reg <= sh_next;
        st_reg <= st_next;
        if (preq.take)
        begin
            take_src_reg <= prsp.from_stack;
            bump_cap_reg <= prsp.bump_slot;
        end
        if (state_reg == S_DEC)
        begin
            gr_reg <= (op_reg == OP_FREE) ? slot_reg : '0;
        end
        else if (state_reg == S_RD && rd_wait_reg)
        begin
            gr_reg <= mrd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ld_reg <= '0;
            pv_reg <= '0;
            fh_reg <= '0;
            eh_reg <= '0;
            fc_reg <= '0;
            ec_reg <= QCNT_W'(SHELL_COUNT);
            rd_wait_reg <= 1'b0;
            for (int i = 0; i < SHELL_COUNT; i++)
            begin
                fill_reg[i] <= '0;
                fq_reg[i] <= '0;
                eq_reg[i] <= SHELL_W'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            ld_reg <= ld_next;
            pv_reg <= pv_next;
            fh_reg <= fh_next;
            eh_reg <= eh_next;
            fc_reg <= fc_next;
            ec_reg <= ec_next;
            rd_wait_reg <= rd_wait_next;
            fill_reg <= fill_next;
            fq_reg <= fq_next;
            eq_reg <= eq_next;
        end
    end

endmodule

/* verif/tb_magazine_slab_slot_allocator.sv */
module tb_magazine_slab_slot_allocator;
    import mssa_pkg::*;

    localparam int MAX_CYCLES = 2000000;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] granted_slot;
    } answer_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  slot_count;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [SLOT_W-1:0] slot_index;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_slot;

    // Allocator state as this bench tracks it.
    logic [SLOT_W-1:0] mag_store [SHELL_COUNT][MAG_DEPTH];
    int unsigned       mag_fill [SHELL_COUNT];
    mag_ref_t          loaded_ref;
    mag_ref_t          prev_ref;
    int unsigned       full_fifo [$];
    int unsigned       shell_fifo [$];
    logic [SLOT_W-1:0] recycle_stack [$];
    int unsigned       bump_ptr;
    int unsigned       pool_size;

    answer_t           pending_answers [$];
    answer_t           last_answer;
    int unsigned       error_count;
    int unsigned       idle_pct;

    magazine_slab_slot_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .slot_count   (slot_count),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .granted_slot (granted_slot)
    );

    always #2 clk = ~clk;

    function automatic int unsigned slots_in_use();
        return (pool_size < POOL_SLOTS) ? pool_size : POOL_SLOTS;
    endfunction

    function automatic logic [SLOT_W-1:0] pop_mag(input int unsigned s);
        if (mag_fill[s] == 0)
        begin
            return '0;
        end
        mag_fill[s]--;
        return mag_store[s][mag_fill[s]];
    endfunction

    function automatic void push_mag(input int unsigned s, input logic [SLOT_W-1:0] v);
        if (mag_fill[s] < MAG_DEPTH)
        begin
            mag_store[s][mag_fill[s]] = v;
            mag_fill[s]++;
        end
    endfunction

    function automatic bit has_slots(input mag_ref_t m);
        return m.present && mag_fill[m.shell] > 0;
    endfunction

    function automatic bit has_room(input mag_ref_t m);
        return m.present && mag_fill[m.shell] < MAG_DEPTH;
    endfunction

    function automatic void swap_mags();
        mag_ref_t t;
        t = loaded_ref;
        loaded_ref = prev_ref;
        prev_ref = t;
    endfunction

    function automatic void install_mag(input int unsigned s);
        if (loaded_ref.present && shell_fifo.size() < SHELL_COUNT)
        begin
            shell_fifo.push_back(loaded_ref.shell);
        end
        loaded_ref.present = 1'b1;
        loaded_ref.shell = SHELL_W'(s);
    endfunction

    function automatic bit take_from_pool(output logic [SLOT_W-1:0] v);
        v = '0;
        if (recycle_stack.size() > 0)
        begin
            v = recycle_stack.pop_back();
            return 1'b1;
        end
        if (bump_ptr < slots_in_use())
        begin
            v = SLOT_W'(bump_ptr);
            bump_ptr++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic answer_t predict_answer(input logic o, input logic [SLOT_W-1:0] idx);
        answer_t a;
        int unsigned s;
        logic [SLOT_W-1:0] v;
        a.status = ST_DONE;
        a.granted_slot = '0;
        if (o == OP_ALLOC)
        begin
            if (has_slots(loaded_ref))
            begin
                a.granted_slot = pop_mag(loaded_ref.shell);
            end
            else if (has_slots(prev_ref))
            begin
                swap_mags();
                a.granted_slot = pop_mag(loaded_ref.shell);
            end
            else if (full_fifo.size() > 0)
            begin
                s = full_fifo.pop_front();
                install_mag(s);
                a.granted_slot = pop_mag(s);
            end
            else if (shell_fifo.size() == 0)
            begin
                a.status = ST_NO_SHELL;
            end
            else
            begin
                s = shell_fifo.pop_front();
                while (mag_fill[s] < MAG_DEPTH && take_from_pool(v))
                begin
                    push_mag(s, v);
                end
                if (mag_fill[s] == 0)
                begin
                    shell_fifo.push_back(s);
                    a.status = ST_NO_SLOTS;
                end
                else
                begin
                    install_mag(s);
                    a.granted_slot = pop_mag(s);
                end
            end
        end
        else
        begin
            a.granted_slot = idx;
            if (idx >= slots_in_use())
            begin
            end
            else if (has_room(loaded_ref))
            begin
                push_mag(loaded_ref.shell, idx);
            end
            else if (has_room(prev_ref))
            begin
                swap_mags();
                push_mag(loaded_ref.shell, idx);
            end
            else
            begin
                if (loaded_ref.present)
                begin
                    if (full_fifo.size() < SHELL_COUNT)
                    begin
                        full_fifo.push_back(loaded_ref.shell);
                    end
                    loaded_ref.present = 1'b0;
                end
                if (shell_fifo.size() > 0)
                begin
                    s = shell_fifo.pop_front();
                    loaded_ref.present = 1'b1;
                    loaded_ref.shell = SHELL_W'(s);
                    push_mag(s, idx);
                end
                else if (recycle_stack.size() < POOL_SLOTS)
                begin
                    recycle_stack.push_back(idx);
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic idle_gap();
        while ($urandom_range(99, 0) < idle_pct)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_word(input logic o, input logic [SLOT_W-1:0] idx);
        @(negedge clk);
        idle_gap();
        in_valid <= 1'b1;
        op <= o;
        slot_index <= idx;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        last_answer = predict_answer(o, idx);
        pending_answers.push_back(last_answer);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (80) @(negedge clk);
    endtask

    task automatic write_pool_size(input int unsigned n);
        wait_drained();
        cfg_valid <= 1'b1;
        slot_count <= CFG_W'(n);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        pool_size = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Only slots that are currently out are freed, apart from deliberate strays.
    logic [SLOT_W-1:0] held_slots [$];

    task automatic alloc_word();
        send_word(OP_ALLOC, SLOT_W'($urandom));
        if (last_answer.status == ST_DONE)
        begin
            held_slots.push_back(last_answer.granted_slot);
        end
    endtask

    task automatic free_held();
        int unsigned k;
        logic [SLOT_W-1:0] v;
        k = $urandom_range(held_slots.size() - 1, 0);
        v = held_slots[k];
        held_slots.delete(k);
        send_word(OP_FREE, v);
    endtask

    task automatic test_directed();
        send_word(OP_FREE, 10'h3FF);
        send_word(OP_FREE, 10'h155);
        repeat (3) alloc_word();
        send_word(OP_FREE, 10'h2AA);
        repeat (3) free_held();
        write_pool_size(1);
        repeat (2) alloc_word();
        send_word(OP_FREE, 10'd1);
        write_pool_size(0);
        alloc_word();
        alloc_word();
        send_word(OP_FREE, 10'd0);
        write_pool_size(2047);
        alloc_word();
        send_word(OP_FREE, 10'h3FF);
        send_word(OP_FREE, 10'h3FF);
    endtask

    task automatic test_exhaust_pool();
        write_pool_size(40);
        repeat (45) alloc_word();
        while (held_slots.size() > 0)
        begin
            free_held();
        end
        repeat (10) alloc_word();
    endtask

    task automatic test_shell_exhaustion();
        int unsigned i;
        write_pool_size(1024);
        for (i = 0; i < 300; i++)
        begin
            send_word(OP_FREE, SLOT_W'(i));
        end
        repeat (20) alloc_word();
        held_slots.delete();
    endtask

    task automatic test_random(input int unsigned cnt);
        int unsigned i;
        for (i = 0; i < cnt; i++)
        begin
            idle_pct = (i >= cnt / 3 && i < cnt / 2) ? 0 : 28;
            if ($urandom_range(99, 0) < 8)
            begin
                send_word(OP_FREE, SLOT_W'($urandom));
            end
            else if (held_slots.size() > 0 && $urandom_range(99, 0) < 48)
            begin
                free_held();
            end
            else
            begin
                alloc_word();
            end
        end
        idle_pct = 28;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        slot_count = '0;
        in_valid = 1'b0;
        op = OP_ALLOC;
        slot_index = '0;
        error_count = 0;
        idle_pct = 28;
        pool_size = 1024;
        bump_ptr = 0;
        loaded_ref = '0;
        prev_ref = '0;
        last_answer = '0;
        for (int i = 0; i < SHELL_COUNT; i++)
        begin
            mag_fill[i] = 0;
            shell_fifo.push_back(i);
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_exhaust_pool();
        test_random(150);
        write_pool_size(64);
        test_random(100);
        test_shell_exhaustion();
        write_pool_size(1024);
        test_random(150);
        wait_drained();
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_stall <= (idle_pct != 0) && ($urandom_range(99, 0) < idle_pct);
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.status)
                begin
                    report_mismatch("status", status, want.status);
                end
                if (granted_slot !== want.granted_slot)
                begin
                    report_mismatch("granted_slot", granted_slot, want.granted_slot);
                end
            end
        end
    end

    initial
    begin
        repeat (MAX_CYCLES) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

endmodule
